// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the gradient filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MGF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define MGF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/mgf_pkg.sv
// ----------------------------------------------------------------------------
// mgf_pkg
// Types, constants and min/max helpers shared by the gradient filter modules.
// ----------------------------------------------------------------------------
package mgf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 7;
    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int LINE_ROWS  = 2 * MAX_RADIUS;
    localparam int TREE_N     = 16;

    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int VROW_W     = ROW_W + 1;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int RAD_W      = 3;
    localparam int CNT_W      = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int LINE_BITS  = LINE_ROWS * PIX_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

    localparam logic [WID_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [HGT_W-1:0] RESET_HEIGHT = 13'd480;
    localparam logic [RAD_W-1:0] RESET_RADIUS = 3'd1;

    // Frame geometry after saturation.
    typedef struct packed {
        logic [COL_W-1:0] w_m1;
        logic [HGT_W-1:0] height;
        logic [RAD_W-1:0] radius;
    } t_geom;

    // One time step of the raster scan as it moves down the pipeline.
    typedef struct packed {
        logic              valid;
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  tx;
        logic [VROW_W-1:0] ty;
        logic              emit;
        logic [COL_W-1:0]  rx;
        logic [ROW_W-1:0]  ry;
        logic              last;
    } t_item;

    // Minimum and maximum of a group of pixels.
    typedef struct packed {
        logic [PIX_W-1:0] mn;
        logic [PIX_W-1:0] mx;
    } t_span;

    localparam t_span SPAN_EMPTY = '{mn: '1, mx: '0};

    function automatic t_span span_merge(input t_span a, input t_span b);
        t_span res;
        res.mn = (a.mn < b.mn) ? a.mn : b.mn;
        res.mx = (a.mx > b.mx) ? a.mx : b.mx;
        return res;
    endfunction

    // Balanced tree reduction over sixteen spans.
    function automatic t_span span_reduce(input t_span [TREE_N-1:0] v);
        t_span [TREE_N-1:0] acc;
        acc = v;
        for (int s = TREE_N / 2; s >= 1; s = s >> 1) begin
            for (int i = 0; i < s; i++) begin
                acc[i] = span_merge(acc[2*i], acc[2*i+1]);
            end
        end
        return acc[0];
    endfunction

endpackage

// File: sv/mgf_ctrl.sv
// ----------------------------------------------------------------------------
// mgf_ctrl
// Configuration registers, raster scan counters and result scheduling.
// ----------------------------------------------------------------------------
module mgf_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mgf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mgf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_op,
    input  logic [mgf_pkg::PIX_W-1:0]      i_pixel,
    output mgf_pkg::t_geom                 o_geom,
    output mgf_pkg::t_item                 o_item
);
    import mgf_pkg::*;

    logic [WID_W-1:0]  r_width;
    logic [HGT_W-1:0]  r_height;
    logic [RAD_W-1:0]  r_radius;
    logic [CNT_W-1:0]  r_t, n_t;
    logic [COL_W-1:0]  r_tx, n_tx, r_rx, n_rx;
    logic [VROW_W-1:0] r_ty, n_ty;
    logic [ROW_W-1:0]  r_ry, n_ry;
    logic              r_in_done, n_in_done;

    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;
    logic [13:0]       lag;
    logic              advance, emit, last, cfg_hit;

    // Saturated geometry and the fixed result lag.
    always_comb begin
        if (r_width == '0) w_eff = WID_W'(1);
        else if (r_width > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
        else w_eff = r_width;
        if (r_height == '0) h_eff = HGT_W'(1);
        else if (r_height > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
        else h_eff = r_height;
    end

    assign w_m1 = COL_W'(w_eff - WID_W'(1));
    assign h_m1 = ROW_W'(h_eff - HGT_W'(1));
    assign lag  = 14'(r_radius) * 14'(w_eff) + 14'(r_radius);

    // A flush before the frame is complete is a no-op; afterwards every
    // transfer is one step of time.
    assign advance = i_accept && (r_in_done || !i_op);
    assign emit    = r_t >= CNT_W'(lag);
    assign last    = (r_rx == w_m1) && (r_ry == h_m1);
    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_FRAME_WIDTH ||
                     i_cfg_idx == CFG_FRAME_HEIGHT || i_cfg_idx == CFG_RADIUS);

    // Next values of the scan and result counters.
    always_comb begin
        n_t       = r_t;
        n_tx      = r_tx;
        n_ty      = r_ty;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_in_done = r_in_done;
        if (advance) begin
            n_t = r_t + CNT_W'(1);
            if (r_tx == w_m1) begin
                n_tx = '0;
                n_ty = r_ty + VROW_W'(1);
            end else begin
                n_tx = r_tx + COL_W'(1);
            end
            if (!r_in_done && r_tx == w_m1 && r_ty == VROW_W'(h_m1)) begin
                n_in_done = 1'b1;
            end
            if (emit) begin
                if (last) begin
                    n_t       = '0;
                    n_tx      = '0;
                    n_ty      = '0;
                    n_rx      = '0;
                    n_ry      = '0;
                    n_in_done = 1'b0;
                end else if (r_rx == w_m1) begin
                    n_rx = '0;
                    n_ry = r_ry + ROW_W'(1);
                end else begin
                    n_rx = r_rx + COL_W'(1);
                end
            end
        end
    end

    // Register writes restart the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RESET_WIDTH;
            r_height  <= RESET_HEIGHT;
            r_radius  <= RESET_RADIUS;
            r_t       <= '0;
            r_tx      <= '0;
            r_ty      <= '0;
            r_rx      <= '0;
            r_ry      <= '0;
            r_in_done <= 1'b0;
        end else if (cfg_hit) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                CFG_RADIUS:       r_radius <= i_cfg_data[RAD_W-1:0];
                default:          r_radius <= r_radius;
            endcase
            r_t       <= '0;
            r_tx      <= '0;
            r_ty      <= '0;
            r_rx      <= '0;
            r_ry      <= '0;
            r_in_done <= 1'b0;
        end else begin
            r_t       <= n_t;
            r_tx      <= n_tx;
            r_ty      <= n_ty;
            r_rx      <= n_rx;
            r_ry      <= n_ry;
            r_in_done <= n_in_done;
        end
    end

    assign o_geom = '{w_m1: w_m1, height: h_eff, radius: r_radius};

    assign o_item = '{valid: advance, pixel: i_pixel, tx: r_tx, ty: r_ty,
                      emit: emit, rx: r_rx, ry: r_ry, last: last};

endmodule

// File: sv/mgf_column.sv
// ----------------------------------------------------------------------------
// mgf_column
// Line memory of the previous rows and the vertical min/max of each column.
// ----------------------------------------------------------------------------
module mgf_column (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  mgf_pkg::t_geom i_geom,
    input  mgf_pkg::t_item i_item,
    output mgf_pkg::t_item o_item,
    output mgf_pkg::t_span o_span
);
    import mgf_pkg::*;

    // One word per column holds that column's last LINE_ROWS pixels,
    // the newest row in the lowest byte.
    logic [LINE_BITS-1:0] r_line_mem [MAX_WIDTH];
    logic [LINE_BITS-1:0] r_rd, r_byp_word;
    logic                 r_byp;
    t_item                r_s1, r_s2;
    t_span                r_span;

    logic [LINE_BITS-1:0] word, wr_word;
    t_span [TREE_N-1:0]   taps;
    logic [VROW_W-1:0]    row_j;

    assign word    = r_byp ? r_byp_word : r_rd;
    assign wr_word = {word[LINE_BITS-PIX_W-1:0], r_s1.pixel};

    // Memory read on transfer; the shifted word is written back from stage r_s1.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_item.valid) r_rd <= r_line_mem[i_item.tx];
            if (r_s1.valid) r_line_mem[r_s1.tx] <= wr_word;
            r_byp_word <= wr_word;
        end
    end

    // Forward the write-back when the next step reads the same column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_en) begin
            r_byp <= r_s1.valid && i_item.valid && (r_s1.tx == i_item.tx);
        end
    end

    // Vertical window: rows ty-2r..ty clipped to the frame.
    always_comb begin
        taps  = '{default: SPAN_EMPTY};
        row_j = '0;
        if (r_s1.ty < VROW_W'(i_geom.height)) begin
            taps[0] = '{mn: r_s1.pixel, mx: r_s1.pixel};
        end
        for (int j = 1; j <= LINE_ROWS; j++) begin
            row_j = r_s1.ty - VROW_W'(j);
            if (4'(j) <= {i_geom.radius, 1'b0} && r_s1.ty >= VROW_W'(j) &&
                row_j < VROW_W'(i_geom.height)) begin
                taps[j] = '{mn: word[(j-1)*PIX_W +: PIX_W],
                            mx: word[(j-1)*PIX_W +: PIX_W]};
            end
        end
    end

    // Pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s1   <= i_item;
            r_s2   <= r_s1;
            r_span <= span_reduce(taps);
        end
    end

    assign o_item = r_s2;
    assign o_span = r_span;

endmodule

// File: sv/mgf_window.sv
// ----------------------------------------------------------------------------
// mgf_window
// Column span history, horizontal min/max and the result register.
// ----------------------------------------------------------------------------
module mgf_window (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  mgf_pkg::t_geom         i_geom,
    input  mgf_pkg::t_item         i_item,
    input  mgf_pkg::t_span         i_span,
    output logic                   o_valid,
    output logic [31:0]            o_data,
    output logic                   o_last
);
    import mgf_pkg::*;

    t_span [LINE_ROWS-1:0] r_hist;
    logic                  r_valid, r_last;
    logic [PIX_W-1:0]      r_gradient;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;

    t_span [TREE_N-1:0]    taps;
    t_span                 win;
    logic [WID_W-1:0]      xr;

    assign xr = WID_W'(i_item.rx) + WID_W'(i_geom.radius);

    // Tap d holds the column span of d steps ago, i.e. column x+r-d.
    always_comb begin
        taps = '{default: SPAN_EMPTY};
        for (int d = 0; d < WIN_SIDE; d++) begin
            if (4'(d) <= {i_geom.radius, 1'b0} && WID_W'(d) <= xr &&
                xr <= WID_W'(i_geom.w_m1) + WID_W'(d)) begin
                taps[d] = (d == 0) ? i_span : r_hist[(d == 0) ? 0 : d-1];
            end
        end
        win = span_reduce(taps);
    end

    // History shifts once per time step.
    always_ff @(posedge i_clk) begin
        if (i_en && i_item.valid) begin
            r_hist <= {r_hist[LINE_ROWS-2:0], i_span};
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_item.valid && i_item.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gradient <= win.mx - win.mn;
            r_col      <= i_item.rx;
            r_row      <= i_item.ry;
            r_last     <= i_item.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {2'b00, r_row, r_col, r_gradient};
    assign o_last  = r_last;

endmodule

// File: sv/morphological_gradient_filter_core.sv
// Stages: r_s1, r_s2, then the result register. Throughput: one transfer
// per cycle while the output is not stalled; the simple dual-port line memory
// does one read and one write-back per cycle, forwarding when a column repeats.
// Reset: synchronous active low; registers return to 640 x 480, radius 1,
// and the frame restarts. The line memory is not cleared.
// ----------------------------------------------------------------------------
// morphological_gradient_filter_core
// Streaming max-minus-min filter over a clipped square window.
// ----------------------------------------------------------------------------
module morphological_gradient_filter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mgf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mgf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] pixel
    input  logic                           i_s_axis_tuser,  // [0] op
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] gradient, [17:8] col, [29:18] row, [31:30] zero
    output logic [31:0]                    o_m_axis_tdata,
    output logic                           o_m_axis_tlast
);
    import mgf_pkg::*;

    logic  en, accept;
    t_geom geom;
    t_item item_in, item_col;
    t_span span_col;

    // The whole pipeline moves whenever the result register can take data.
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;

    mgf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_op       (i_s_axis_tuser),
        .i_pixel    (i_s_axis_tdata),
        .o_geom     (geom),
        .o_item     (item_in)
    );

    mgf_column u_column (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_geom  (geom),
        .i_item  (item_in),
        .o_item  (item_col),
        .o_span  (span_col)
    );

    mgf_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_geom  (geom),
        .i_item  (item_col),
        .i_span  (span_col),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// File: sv/mgf_checker.sv
// ----------------------------------------------------------------------------
// mgf_checker
// Port-level checks of the gradient filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mgf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [mgf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [mgf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [7:0]                     i_s_axis_tdata,
    input logic                           i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [31:0]                    o_m_axis_tdata,
    input logic                           o_m_axis_tlast
);

    // A stalled result stays offered.
    `MGF_ASSERT(a_valid_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `MGF_ASSERT(a_data_hold, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "result changed while stalled")

    // With the result register empty the input side is never blocked.
    `MGF_ASSERT(a_ready_when_empty, !o_m_axis_tvalid |-> o_s_axis_tready, "input blocked with empty output")

    // Reset leaves no result pending.
    `MGF_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_m_axis_tvalid, "result present after reset")

endmodule

bind morphological_gradient_filter_core mgf_checker u_mgf_checker (.*);
